@@ rtl/mqrb_pkg.sv @@
`timescale 1ns / 1ps

package mqrb_pkg;

  localparam int NUM_QUEUES    = 8;
  localparam int ELEMENT_WIDTH = 8;
  localparam int STORE_DEPTH   = 256;

  localparam int HANDLE_W = 3;
  localparam int COUNT_W  = 4;
  localparam int ADDR_W   = 8;
  localparam int LEN_W    = 9;
  localparam int SUM_W    = 10;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 3;

  typedef logic [CMD_W-1:0]    command_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  localparam command_t CMD_CLAIM  = 3'd0;
  localparam command_t CMD_INIT   = 3'd1;
  localparam command_t CMD_RETURN = 3'd2;
  localparam command_t CMD_PUSH   = 3'd3;
  localparam command_t CMD_POP    = 3'd4;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_EMPTY      = 3'd2;
  localparam status_t ST_NONE_FREE  = 3'd3;
  localparam status_t ST_DUPLICATE  = 3'd4;
  localparam status_t ST_NOT_INIT   = 3'd5;
  localparam status_t ST_BAD_REGION = 3'd6;

  typedef struct packed {
    command_t                 command;
    handle_t                  handle;
    logic [ELEMENT_WIDTH-1:0] push_value;
    logic [ADDR_W-1:0]        region_base;
    logic [LEN_W-1:0]         region_length;
  } cmd_item_t;

  typedef struct packed {
    status_t                  status;
    handle_t                  result_handle;
    logic [ELEMENT_WIDTH-1:0] pop_value;
    logic                     queue_empty;
    logic                     queue_full;
    logic [COUNT_W-1:0]       used_slots;
  } rsp_item_t;

  // free list -> top
  typedef struct packed {
    logic               none_free;
    logic               duplicate;
    handle_t            grant;
    logic [COUNT_W-1:0] used_slots;
  } fl_res_t;

  // queue contexts -> top and element store
  typedef struct packed {
    status_t status;
    logic    queue_empty;
    logic    queue_full;
    logic    wr_en;
    addr_t   wr_addr;
    logic    pop_ok;
    addr_t   rd_addr;
  } ctx_res_t;

endpackage

@@ rtl/mqrb_free_list.sv @@
`timescale 1ns / 1ps

module mqrb_free_list (
  input  logic              clk,
  input  logic              rst,
  input  logic              claim,
  input  logic              release_req,
  input  mqrb_pkg::handle_t handle,
  output mqrb_pkg::fl_res_t res
);
  import mqrb_pkg::*;

  handle_t              free_stack [NUM_QUEUES];
  logic [COUNT_W-1:0]   free_count;
  logic [NUM_QUEUES-1:0] handle_free;

  logic [COUNT_W-1:0]   free_count_next;
  handle_t              top_idx;
  handle_t              push_idx;
  logic                 claim_ok;
  logic                 return_ok;

  assign top_idx  = free_count[HANDLE_W-1:0] - HANDLE_W'(1);
  assign push_idx = free_count[HANDLE_W-1:0];

  assign res.none_free = (free_count == '0);
  assign res.duplicate = handle_free[handle] || (free_count >= COUNT_W'(NUM_QUEUES));
  assign res.grant     = free_stack[top_idx];

  assign claim_ok  = claim && !res.none_free;
  assign return_ok = release_req && !res.duplicate;

  always_comb begin
    free_count_next = free_count;
    if (claim_ok) begin
      free_count_next = free_count - COUNT_W'(1);
    end else if (return_ok) begin
      free_count_next = free_count + COUNT_W'(1);
    end
  end

  assign res.used_slots = COUNT_W'(NUM_QUEUES) - free_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        free_stack[i] <= HANDLE_W'(i);
      end
      free_count  <= COUNT_W'(NUM_QUEUES);
      handle_free <= '1;
    end else begin
      free_count <= free_count_next;
      if (claim_ok) begin
        handle_free[res.grant] <= 1'b0;
      end else if (return_ok) begin
        free_stack[push_idx] <= handle;
        handle_free[handle]  <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/mqrb_ctx.sv @@
`timescale 1ns / 1ps

module mqrb_ctx (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  logic                               handle_ok,
  input  mqrb_pkg::command_t                 command,
  input  mqrb_pkg::handle_t                  handle,
  input  mqrb_pkg::handle_t                  flag_handle,
  input  logic [mqrb_pkg::ADDR_W-1:0]        region_base,
  input  logic [mqrb_pkg::LEN_W-1:0]         region_length,
  output mqrb_pkg::ctx_res_t                 res
);
  import mqrb_pkg::*;

  addr_t                 region_first  [NUM_QUEUES];
  addr_t                 region_last   [NUM_QUEUES];
  addr_t                 read_pointer  [NUM_QUEUES];
  addr_t                 write_pointer [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] queue_ready;
  logic [NUM_QUEUES-1:0] empty_flag;
  logic [NUM_QUEUES-1:0] full_flag;

  addr_t            first_q;
  addr_t            last_q;
  addr_t            rp;
  addr_t            wp;
  addr_t            rp_next;
  addr_t            wp_next;
  addr_t            rp_step;
  addr_t            wp_step;
  logic             empty_next;
  logic             full_next;
  logic             init_ok;
  logic             bad_region;
  logic [SUM_W-1:0] region_end;
  status_t          status;
  logic             wr_en;
  logic             pop_ok;
  logic             flag_empty;
  logic             flag_full;

  assign first_q = region_first[handle];
  assign last_q  = region_last[handle];
  assign rp      = read_pointer[handle];
  assign wp      = write_pointer[handle];

  // pointer advance with wrap at the region end
  assign rp_step = (rp >= last_q) ? first_q : rp + ADDR_W'(1);
  assign wp_step = (wp >= last_q) ? first_q : wp + ADDR_W'(1);

  assign region_end = SUM_W'(region_base) + SUM_W'(region_length);
  assign bad_region = (region_length == '0) || (region_end > SUM_W'(STORE_DEPTH));

  always_comb begin
    status      = ST_OK;
    rp_next     = rp;
    wp_next     = wp;
    empty_next  = empty_flag[handle];
    full_next   = full_flag[handle];
    init_ok     = 1'b0;
    wr_en       = 1'b0;
    pop_ok      = 1'b0;
    if (handle_ok) begin
      case (command)
        CMD_INIT: begin
          if (bad_region) begin
            status = ST_BAD_REGION;
          end else begin
            init_ok    = 1'b1;
            empty_next = 1'b1;
            full_next  = 1'b0;
          end
        end
        CMD_PUSH: begin
          if (!queue_ready[handle]) begin
            status = ST_NOT_INIT;
          end else if (full_flag[handle]) begin
            status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            wp_next    = wp_step;
            empty_next = 1'b0;
            full_next  = (wp_step == rp);
          end
        end
        CMD_POP: begin
          if (!queue_ready[handle]) begin
            status = ST_NOT_INIT;
          end else if (empty_flag[handle]) begin
            status = ST_EMPTY;
          end else begin
            pop_ok     = 1'b1;
            rp_next    = rp_step;
            full_next  = 1'b0;
            empty_next = (wp == rp_step);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a claim leaves contexts alone; its flags are those held for flag_handle
  always_comb begin
    if (command == CMD_CLAIM) begin
      flag_empty = empty_flag[flag_handle];
      flag_full  = full_flag[flag_handle];
    end else begin
      flag_empty = empty_next;
      flag_full  = full_next;
    end
    if (!handle_ok && command != CMD_CLAIM) begin
      flag_empty = 1'b1;
      flag_full  = 1'b0;
    end
  end

  assign res.status      = status;
  assign res.queue_empty = flag_empty;
  assign res.queue_full  = flag_full;
  assign res.wr_en       = wr_en;
  assign res.wr_addr     = wp;
  assign res.pop_ok      = pop_ok;
  assign res.rd_addr     = rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        region_first[i]  <= '0;
        region_last[i]   <= '0;
        read_pointer[i]  <= '0;
        write_pointer[i] <= '0;
      end
      queue_ready <= '0;
      empty_flag  <= '1;
      full_flag   <= '0;
    end else if (go && handle_ok) begin
      empty_flag[handle]    <= empty_next;
      full_flag[handle]     <= full_next;
      read_pointer[handle]  <= rp_next;
      write_pointer[handle] <= wp_next;
      if (init_ok) begin
        region_first[handle]  <= region_base;
        region_last[handle]   <= region_base + region_length[ADDR_W-1:0] - ADDR_W'(1);
        read_pointer[handle]  <= region_base;
        write_pointer[handle] <= region_base;
        queue_ready[handle]   <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/mqrb_store.sv @@
`timescale 1ns / 1ps

module mqrb_store (
  input  logic                                clk,
  input  logic                                wr_en,
  input  mqrb_pkg::addr_t                     wr_addr,
  input  logic [mqrb_pkg::ELEMENT_WIDTH-1:0]  wr_data,
  input  logic                                rd_en,
  input  mqrb_pkg::addr_t                     rd_addr,
  output logic [mqrb_pkg::ELEMENT_WIDTH-1:0]  rd_data
);
  import mqrb_pkg::*;

  logic [ELEMENT_WIDTH-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/multi_queue_ring_buffer_pool.sv @@
// Pool of eight ring-buffer queues sharing one 256-entry element store.
// Command channel (cmd_valid / cmd_stall / cmd): claim, init region, return,
// push and pop. Every command gives exactly one item on the response channel
// (rsp_valid / rsp_stall / rsp): status, handle, popped element, the queue's
// empty and full flags after the command, and the number of claimed handles.
// A command is registered on acceptance, then decoded and applied to the free
// list and the queue contexts, and its response is registered when it is applied.
// One command is taken every cycle while no stalled response is pending; the
// store has one write port for pushes and one registered read port for pops,
// so a pop right after a push to the same queue sees the pushed element.
// Synchronous reset returns all handles to the free list, marks every queue
// uninitialised and empty, and drops both valid registers; store contents
// are not cleared and no clearing pass is needed.
// When rsp_stall is high with a response pending, the response holds and the
// command register stops; cmd_stall rises once it is occupied and cannot drain.
`timescale 1ns / 1ps

module multi_queue_ring_buffer_pool (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  mqrb_pkg::cmd_item_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mqrb_pkg::rsp_item_t rsp
);
  import mqrb_pkg::*;

  logic      s1_valid;
  cmd_item_t s1_item;
  logic      go;
  logic      handle_ok;
  fl_res_t   fl_res;
  ctx_res_t  ctx_res;
  handle_t   flag_handle;
  status_t   status_next;

  status_t                  rsp_status;
  handle_t                  rsp_handle;
  logic                     rsp_empty;
  logic                     rsp_full;
  logic [COUNT_W-1:0]       rsp_used;
  logic                     rsp_pop_ok;
  logic [ELEMENT_WIDTH-1:0] pop_data;

  assign go        = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && !go;
  assign handle_ok = int'(s1_item.handle) < NUM_QUEUES;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall) begin
      s1_item <= cmd;
    end
  end

  mqrb_free_list u_free_list (
    .clk         (clk),
    .rst         (rst),
    .claim       (go && s1_item.command == CMD_CLAIM),
    .release_req (go && s1_item.command == CMD_RETURN && handle_ok),
    .handle      (s1_item.handle),
    .res         (fl_res)
  );

  assign flag_handle = fl_res.none_free ? s1_item.handle : fl_res.grant;

  mqrb_ctx u_ctx (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .handle_ok     (handle_ok),
    .command       (s1_item.command),
    .handle        (s1_item.handle),
    .flag_handle   (flag_handle),
    .region_base   (s1_item.region_base),
    .region_length (s1_item.region_length),
    .res           (ctx_res)
  );

  mqrb_store u_store (
    .clk     (clk),
    .wr_en   (go && ctx_res.wr_en),
    .wr_addr (ctx_res.wr_addr),
    .wr_data (s1_item.push_value),
    .rd_en   (go),
    .rd_addr (ctx_res.rd_addr),
    .rd_data (pop_data)
  );

  always_comb begin
    status_next = ST_OK;
    if (s1_item.command == CMD_CLAIM) begin
      status_next = fl_res.none_free ? ST_NONE_FREE : ST_OK;
    end else if (s1_item.command <= CMD_POP && !handle_ok) begin
      status_next = ST_NOT_INIT;
    end else if (s1_item.command == CMD_RETURN) begin
      status_next = fl_res.duplicate ? ST_DUPLICATE : ST_OK;
    end else if (s1_item.command <= CMD_POP) begin
      status_next = ctx_res.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp_status <= status_next;
      rsp_handle <= (s1_item.command == CMD_CLAIM) ? flag_handle : s1_item.handle;
      rsp_empty  <= ctx_res.queue_empty;
      rsp_full   <= ctx_res.queue_full;
      rsp_used   <= fl_res.used_slots;
      rsp_pop_ok <= (s1_item.command == CMD_POP) && ctx_res.pop_ok;
    end
  end

  assign rsp.status        = rsp_status;
  assign rsp.result_handle = rsp_handle;
  assign rsp.pop_value     = rsp_pop_ok ? pop_data : '0;
  assign rsp.queue_empty   = rsp_empty;
  assign rsp.queue_full    = rsp_full;
  assign rsp.used_slots    = rsp_used;

endmodule

@@ rtl/mqrb_checker.sv @@
`timescale 1ns / 1ps

module mqrb_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input mqrb_pkg::rsp_item_t rsp
);
  import mqrb_pkg::*;

  // nothing can come out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.used_slots <= COUNT_W'(NUM_QUEUES))
    else $error("used slot count beyond pool size");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.queue_empty && rsp.queue_full))
    else $error("queue reported empty and full");

  a_pop_value_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pop_value != '0 |-> rsp.status == ST_OK)
    else $error("nonzero element on a failed command");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind multi_queue_ring_buffer_pool mqrb_checker u_mqrb_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import mqrb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_item_t rsp;

  multi_queue_ring_buffer_pool dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // pool state as the block should hold it
  handle_t                  free_handles [NUM_QUEUES];
  int                       free_total;
  bit                       is_free      [NUM_QUEUES];
  bit                       ctx_ready    [NUM_QUEUES];
  addr_t                    first_addr   [NUM_QUEUES];
  addr_t                    last_addr    [NUM_QUEUES];
  addr_t                    rd_ptr       [NUM_QUEUES];
  addr_t                    wr_ptr       [NUM_QUEUES];
  bit                       empty_bit    [NUM_QUEUES];
  bit                       is_full      [NUM_QUEUES];
  logic [ELEMENT_WIDTH-1:0] element_mem  [STORE_DEPTH];

  rsp_item_t awaited_rsp[$];
  rsp_item_t want_rsp;
  int        error_count = 0;
  int        cycle_count = 0;
  int        cmd_gap_odds = 0;
  int        rsp_stall_odds = 0;
  int        long_hold_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic addr_t next_slot(handle_t h, addr_t p);
    return (p >= last_addr[h]) ? first_addr[h] : addr_t'(p + 1);
  endfunction

  // applies one command to the pool state and gives the response it must cause
  function automatic rsp_item_t apply_pool_command(cmd_item_t c);
    rsp_item_t r;
    handle_t   h;
    int        region_end;
    r = '0;
    h = c.handle;
    r.status = ST_OK;
    region_end = int'(c.region_base) + int'(c.region_length);
    case (c.command)
      CMD_CLAIM: begin
        if (free_total == 0) begin
          r.status = ST_NONE_FREE;
        end else begin
          free_total--;
          h = free_handles[free_total];
          is_free[h] = 1'b0;
        end
      end
      CMD_INIT: begin
        if (c.region_length == 0 || region_end > STORE_DEPTH) begin
          r.status = ST_BAD_REGION;
        end else begin
          first_addr[h] = c.region_base;
          last_addr[h] = addr_t'(region_end - 1);
          rd_ptr[h] = c.region_base;
          wr_ptr[h] = c.region_base;
          empty_bit[h] = 1'b1;
          is_full[h] = 1'b0;
          ctx_ready[h] = 1'b1;
        end
      end
      CMD_RETURN: begin
        if (is_free[h] || free_total >= NUM_QUEUES) begin
          r.status = ST_DUPLICATE;
        end else begin
          free_handles[free_total] = h;
          free_total++;
          is_free[h] = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (!ctx_ready[h]) begin
          r.status = ST_NOT_INIT;
        end else if (is_full[h]) begin
          r.status = ST_FULL;
        end else begin
          element_mem[wr_ptr[h]] = c.push_value;
          wr_ptr[h] = next_slot(h, wr_ptr[h]);
          empty_bit[h] = 1'b0;
          if (wr_ptr[h] == rd_ptr[h]) is_full[h] = 1'b1;
        end
      end
      CMD_POP: begin
        if (!ctx_ready[h]) begin
          r.status = ST_NOT_INIT;
        end else if (empty_bit[h]) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = element_mem[rd_ptr[h]];
          rd_ptr[h] = next_slot(h, rd_ptr[h]);
          is_full[h] = 1'b0;
          if (wr_ptr[h] == rd_ptr[h]) empty_bit[h] = 1'b1;
        end
      end
      default: begin
        // unused command codes leave everything alone
      end
    endcase
    r.result_handle = h;
    r.queue_empty = empty_bit[h];
    r.queue_full = is_full[h];
    r.used_slots = COUNT_W'(NUM_QUEUES - free_total);
    return r;
  endfunction

  // offers one item, waits for it to be taken, then records its response
  task automatic send_cmd(cmd_item_t c);
    if ($urandom_range(0, 15) < cmd_gap_odds) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    awaited_rsp.push_back(apply_pool_command(c));
  endtask

  task automatic send_fields(command_t op, int h, int value, int base, int len);
    cmd_item_t c;
    c.command = op;
    c.handle = handle_t'(h);
    c.push_value = value[ELEMENT_WIDTH-1:0];
    c.region_base = base[ADDR_W-1:0];
    c.region_length = len[LEN_W-1:0];
    send_cmd(c);
  endtask

  // receiver side: random stall bursts, or one long hold-off when asked
  initial begin : rsp_side
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
        rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 15) < rsp_stall_odds) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("rsp item with none awaited: %h", rsp);
      end else begin
        want_rsp = awaited_rsp.pop_front();
        if (rsp.status !== want_rsp.status || rsp.result_handle !== want_rsp.result_handle ||
            rsp.pop_value !== want_rsp.pop_value || rsp.queue_empty !== want_rsp.queue_empty ||
            rsp.queue_full !== want_rsp.queue_full || rsp.used_slots !== want_rsp.used_slots) begin
          error_count++;
          if (error_count <= 10) begin
            $display("rsp mismatch (exp/got): status %0d/%0d handle %0d/%0d pop %h/%h",
                     want_rsp.status, rsp.status, want_rsp.result_handle, rsp.result_handle,
                     want_rsp.pop_value, rsp.pop_value,
                     " empty %b/%b full %b/%b used %0d/%0d",
                     want_rsp.queue_empty, rsp.queue_empty, want_rsp.queue_full,
                     rsp.queue_full, want_rsp.used_slots, rsp.used_slots);
          end
        end
      end
    end
  end

  task automatic test_free_list();
    send_fields(CMD_RETURN, 0, 8'h00, 0, 0);       // nothing claimed yet
    repeat (NUM_QUEUES + 1) send_fields(CMD_CLAIM, 0, 8'hff, 8'hff, 9'h1ff);
    send_fields(CMD_RETURN, 5, 0, 0, 0);
    send_fields(CMD_RETURN, 5, 0, 0, 0);            // second return of the same handle
  endtask

  task automatic test_region_setup();
    send_fields(CMD_PUSH, 2, 8'h3c, 0, 0);          // queue not set up yet
    send_fields(CMD_INIT, 2, 0, 0, 0);              // empty region
    send_fields(CMD_INIT, 2, 0, 255, 2);            // runs past the store end
    send_fields(CMD_INIT, 2, 0, 0, STORE_DEPTH);    // whole store
    send_fields(CMD_PUSH, 2, 8'hff, 0, 0);
    send_fields(CMD_POP, 2, 0, 0, 0);
  endtask

  task automatic test_wrap_and_flags();
    send_fields(CMD_INIT, 7, 0, 255, 1);            // single slot at the top
    send_fields(CMD_PUSH, 7, 8'ha5, 0, 0);
    send_fields(CMD_PUSH, 7, 8'h5a, 0, 0);          // full
    send_fields(CMD_POP, 7, 0, 0, 0);
    send_fields(CMD_POP, 7, 0, 0, 0);               // empty
  endtask

  task automatic test_unused_command();
    send_fields(command_t'(7), 4, 8'hff, 8'hff, 9'h1ff);
  endtask

  // mostly well-formed traffic on small regions, with some bad setups mixed in
  task automatic test_random_traffic(int count, int gap_odds, int stall_odds);
    cmd_item_t c;
    int        pick;
    int        len;
    cmd_gap_odds = gap_odds;
    rsp_stall_odds = stall_odds;
    repeat (count) begin
      c.handle = handle_t'($urandom_range(0, NUM_QUEUES - 1));
      c.push_value = ELEMENT_WIDTH'($urandom);
      c.region_base = addr_t'($urandom);
      c.region_length = LEN_W'($urandom_range(0, 511));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        c.command = CMD_CLAIM;
      end else if (pick < 16) begin
        c.command = CMD_RETURN;
      end else if (pick < 26) begin
        c.command = CMD_INIT;
        if ($urandom_range(0, 9) != 0) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, STORE_DEPTH) :
                $urandom_range(1, 12);
          c.region_length = len[LEN_W-1:0];
          c.region_base = addr_t'($urandom_range(0, STORE_DEPTH - len));
        end
      end else if (pick < 60) begin
        c.command = CMD_PUSH;
      end else if (pick < 96) begin
        c.command = CMD_POP;
      end else begin
        c.command = command_t'($urandom_range(5, 7));
      end
      send_cmd(c);
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    cmd_gap_odds = 0;
    rsp_stall_odds = 0;
    send_fields(CMD_INIT, 3, 0, 16, 6);
    long_hold_cycles = 60;
    repeat (12) begin
      send_fields(CMD_PUSH, 3, $urandom, 0, 0);
      send_fields(CMD_POP, 3, 0, 0, 0);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      free_handles[i] = handle_t'(i);
      is_free[i] = 1'b1;
      ctx_ready[i] = 1'b0;
      first_addr[i] = '0;
      last_addr[i] = '0;
      rd_ptr[i] = '0;
      wr_ptr[i] = '0;
      empty_bit[i] = 1'b1;
      is_full[i] = 1'b0;
    end
    free_total = NUM_QUEUES;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    cmd_gap_odds = 3;
    rsp_stall_odds = 3;
    test_free_list();
    test_region_setup();
    test_wrap_and_flags();
    test_unused_command();
    test_random_traffic(250, 4, 4);
    test_backpressure();
    test_random_traffic(150, 8, 1);
    test_random_traffic(150, 1, 8);
    test_random_traffic(200, 0, 0);
    cmd_valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
